/* rtl/bmp_pixel_unpacker_core_defines.svh */
// Assertion macros shared by the BMP pixel unpacker RTL.
// Depends on nothing; files that check their logic include it by name.
`ifndef BMP_PIXEL_UNPACKER_CORE_DEFINES_SVH
`define BMP_PIXEL_UNPACKER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BPU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define BPU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BPU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define BPU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/bpu_pkg.sv */
// Shared types and constants of the BMP pixel unpacker.
// Depends on nothing; used by the position tracker and the top level.
package bpu_pkg;

   localparam int MAX_DIMENSION = 4096;
   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
   localparam int RGB_W         = 24;
   localparam int CFG_W         = 13;
   localparam int BPP_W         = 6;
   localparam int CSR_IDX_W     = 2;
   localparam int CNT_W         = $clog2(MAX_DIMENSION + 1);
   localparam int COL_W         = 12;
   localparam int MAX_RESULTS   = 8;
   localparam int RUN_W         = $clog2(MAX_RESULTS + 1);
   localparam int SLOT_W        = $clog2(MAX_RESULTS);

   localparam logic MODE_PALETTE = 1'b0;
   localparam logic MODE_DATA    = 1'b1;

   localparam logic [1:0] STATUS_PIXEL       = 2'd0;
   localparam logic [1:0] STATUS_UNSUPPORTED = 2'd1;
   localparam logic [1:0] STATUS_OVERRUN     = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BITS_PER_PIXEL = 2'd2;

   localparam logic [BPP_W-1:0] BPP_1  = 6'd1;
   localparam logic [BPP_W-1:0] BPP_4  = 6'd4;
   localparam logic [BPP_W-1:0] BPP_8  = 6'd8;
   localparam logic [BPP_W-1:0] BPP_24 = 6'd24;

   typedef enum logic [2:0] {
      KIND_ERROR,
      KIND_PAL1,
      KIND_PAL4,
      KIND_PAL8,
      KIND_RGB
   } job_kind_type;

   typedef struct packed {
      logic         mode;
      logic [7:0]   data_byte;
      logic [7:0]   palette_index;
      logic [7:0]   palette_red;
      logic [7:0]   palette_green;
      logic [7:0]   palette_blue;
   } req_payload_type;

   typedef struct packed {
      logic [COL_W-1:0] pixel_column;
      logic [COL_W-1:0] pixel_row;
      logic [7:0]       out_red;
      logic [7:0]       out_green;
      logic [7:0]       out_blue;
      logic [1:0]       status;
      logic             last_of_run;
      logic             frame_done;
   } rsp_payload_type;

   // Work that one data byte leaves for the lookup pipeline.
   typedef struct packed {
      logic               valid;
      job_kind_type       kind;
      logic [1:0]         status;
      logic [RUN_W-1:0]   count;
      logic [CNT_W-1:0]   first_col;
      logic [CNT_W-1:0]   last_col;
      logic [COL_W-1:0]   row_out;
      logic               last_row;
      logic [7:0]         data_byte;
      logic [RGB_W-1:0]   rgb;
   } job_type;

endpackage

/* rtl/bpu_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; holds the palette of the BMP pixel unpacker.
module bpu_ram #(
   parameter int WIDTH  = 24,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/bpu_position.sv */
// Configuration registers and frame position tracking of the BMP pixel unpacker.
// Depends on bpu_pkg; turns accepted data bytes into lookup jobs.
module bpu_position (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [bpu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpu_pkg::CFG_W-1:0]      csr_wdata,
   input  logic                           byte_accept,
   input  logic [7:0]                     data_byte,
   output bpu_pkg::job_type               job
);
   import bpu_pkg::*;

   function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (v > CFG_W'(MAX_DIMENSION)) begin
         r = CNT_W'(MAX_DIMENSION);
      end else begin
         r = CNT_W'(v);
      end
      return r;
   endfunction

   logic [CFG_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [BPP_W-1:0] bpp_ff, bpp_in;
   logic [CNT_W-1:0] col_ff, col_in, srow_ff, srow_in;
   logic [1:0]       rbp_ff, rbp_in, rgbp_ff, rgbp_in;
   logic [15:0]      held_ff, held_in;
   logic             pad_ff, pad_in;

   logic [CNT_W-1:0] w, h, avail, col_new;
   logic [RUN_W-1:0] cap, n;
   logic [1:0]       rbp_next, rgbp_next;
   logic [15:0]      held_next;
   logic             supported, overrun, is_rgb;

   assign w         = clamp_dim(width_ff);
   assign h         = clamp_dim(height_ff);
   assign is_rgb    = (bpp_ff == BPP_24);
   assign supported = (bpp_ff == BPP_1) || (bpp_ff == BPP_4) || (bpp_ff == BPP_8) || is_rgb;
   assign overrun   = (srow_ff >= h);
   assign avail     = (col_ff < w) ? (w - col_ff) : '0;
   assign rbp_next  = rbp_ff + 2'd1;

   always_comb begin
      unique case (bpp_ff)
         BPP_1:   cap = RUN_W'(8);
         BPP_4:   cap = RUN_W'(2);
         BPP_8:   cap = RUN_W'(1);
         BPP_24:  cap = (rgbp_ff == 2'd2) ? RUN_W'(1) : '0;
         default: cap = '0;
      endcase
   end

   assign n       = (avail < CNT_W'(cap)) ? RUN_W'(avail) : cap;
   assign col_new = col_ff + CNT_W'(n);

   // Blue arrives first, then green, then red completes the pixel.
   always_comb begin
      rgbp_next = rgbp_ff;
      held_next = held_ff;
      if (is_rgb) begin
         unique case (rgbp_ff)
            2'd0: begin
               held_next = {8'h00, data_byte};
               rgbp_next = 2'd1;
            end
            2'd1: begin
               held_next = {data_byte, held_ff[7:0]};
               rgbp_next = 2'd2;
            end
            default: begin
               rgbp_next = 2'd0;
            end
         endcase
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      bpp_in    = bpp_ff;
      col_in    = col_ff;
      srow_in   = srow_ff;
      rbp_in    = rbp_ff;
      rgbp_in   = rgbp_ff;
      held_in   = held_ff;
      pad_in    = pad_ff;
      if (csr_we && (csr_index == REG_IMAGE_WIDTH || csr_index == REG_IMAGE_HEIGHT ||
                     csr_index == REG_BITS_PER_PIXEL)) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = csr_wdata;
            REG_IMAGE_HEIGHT: height_in = csr_wdata;
            default:          bpp_in    = csr_wdata[BPP_W-1:0];
         endcase
         col_in  = '0;
         srow_in = '0;
         rbp_in  = '0;
         rgbp_in = '0;
         held_in = '0;
         pad_in  = 1'b0;
      end else if (byte_accept) begin
         priority if (pad_ff) begin
            rbp_in = rbp_next;
            if (rbp_next == 2'd0) begin
               col_in  = '0;
               srow_in = srow_ff + CNT_W'(1);
               pad_in  = 1'b0;
            end
         end else if (overrun || !supported) begin
            // Error bytes leave the position untouched.
         end else begin
            col_in  = col_new;
            rgbp_in = rgbp_next;
            held_in = held_next;
            rbp_in  = rbp_next;
            if (col_new >= w && (!is_rgb || rgbp_next == 2'd0)) begin
               if (rbp_next == 2'd0) begin
                  col_in  = '0;
                  srow_in = srow_ff + CNT_W'(1);
               end else begin
                  pad_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(1);
         height_ff <= CFG_W'(1);
         bpp_ff    <= BPP_24;
         col_ff    <= '0;
         srow_ff   <= '0;
         rbp_ff    <= '0;
         rgbp_ff   <= '0;
         held_ff   <= '0;
         pad_ff    <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         bpp_ff    <= bpp_in;
         col_ff    <= col_in;
         srow_ff   <= srow_in;
         rbp_ff    <= rbp_in;
         rgbp_ff   <= rgbp_in;
         held_ff   <= held_in;
         pad_ff    <= pad_in;
      end
   end

   always_comb begin
      job           = '0;
      job.first_col = col_ff;
      job.last_col  = w - CNT_W'(1);
      job.row_out   = COL_W'(h - CNT_W'(1) - srow_ff);
      job.last_row  = (srow_ff == h - CNT_W'(1));
      job.data_byte = data_byte;
      job.rgb       = {data_byte, held_ff[15:8], held_ff[7:0]};
      job.status    = STATUS_PIXEL;
      job.count     = n;
      job.kind      = KIND_ERROR;
      priority if (pad_ff) begin
         job.valid = 1'b0;
      end else if (overrun) begin
         job.valid  = 1'b1;
         job.status = STATUS_OVERRUN;
         job.count  = RUN_W'(1);
      end else if (!supported) begin
         job.valid  = 1'b1;
         job.status = STATUS_UNSUPPORTED;
         job.count  = RUN_W'(1);
      end else begin
         job.valid = (n != '0);
         unique case (bpp_ff)
            BPP_1:   job.kind = KIND_PAL1;
            BPP_4:   job.kind = KIND_PAL4;
            BPP_8:   job.kind = KIND_PAL8;
            default: job.kind = KIND_RGB;
         endcase
      end
   end

endmodule

/* rtl/bmp_pixel_unpacker_core.sv */
// BMP pixel unpacker top level: handshake, palette lookup pipeline, output register.
// Depends on bpu_pkg, bpu_ram, bpu_position and the assertion macro header.
// The first result of a transaction passes through stage A, stage B and the output register.
// Throughput: one lookup per cycle through the palette RAM read port unless the output stalls,
// so one byte per cycle at 8 and 24 bits per pixel, while a byte at 4 or 1 waits for its up to two or eight lookups.
// Reset clears all control state and loads width 1, height 1 and 24 bits per pixel;
// the palette is not cleared, so an entry must be written before it is looked up.
`include "bmp_pixel_unpacker_core_defines.svh"
module bmp_pixel_unpacker_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  bpu_pkg::req_payload_type       req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bpu_pkg::rsp_payload_type       rsp_payload,
   input  logic                           csr_we,
   input  logic [bpu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpu_pkg::CFG_W-1:0]      csr_wdata
);
   import bpu_pkg::*;

   // Input side. A transaction is either a palette write or a data byte. Palette
   // writes go straight into the RAM. A data byte is handed to the position
   // tracker, which updates the frame position at once and describes the results
   // that the byte causes as a job.
   logic    req_accept, byte_accept, pal_we;
   job_type job;

   // Stage A holds the current job and issues one lookup per cycle while stage B is free.
   logic             a_valid_ff, a_valid_in;
   job_type          a_job_ff, a_job_in;
   logic [RUN_W-1:0] a_cnt_ff, a_cnt_in;
   logic [SLOT_W-1:0] a_k_ff, a_k_in;
   logic [CNT_W-1:0] a_col_ff, a_col_in;
   logic             issue, a_last, a_error, use_ram;
   logic [PAL_AW-1:0] rd_addr;

   // Stage B lines up with the registered RAM read data.
   logic             b_valid_ff, b_valid_in;
   logic             b_use_ram_ff, b_use_ram_in;
   logic [RGB_W-1:0] b_rgb_ff, b_rgb_in;
   logic [COL_W-1:0] b_col_ff, b_col_in, b_row_ff, b_row_in;
   logic [1:0]       b_status_ff, b_status_in;
   logic             b_last_ff, b_last_in, b_done_ff, b_done_in;
   logic             b_free, b_move;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_ff, rsp_in;
   logic             out_free;
   logic [RGB_W-1:0] ram_rdata, color;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign b_free   = !b_valid_ff || out_free;
   assign b_move   = b_valid_ff && out_free;
   assign issue    = a_valid_ff && b_free;
   assign a_last   = (a_cnt_ff == RUN_W'(1));

   // A new transaction is taken when no job is held or the current job issues its last lookup. A
   // palette write accepted in that same cycle does not disturb that read, since
   // the RAM returns the old contents on a same-address collision, and every
   // later read sees the new entry.
   assign req_ready   = !a_valid_ff || (issue && a_last);
   assign req_accept  = req_valid && req_ready;
   assign byte_accept = req_accept && (req_payload.mode == MODE_DATA);
   assign pal_we      = req_accept && (req_payload.mode == MODE_PALETTE);

   bpu_position u_position (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .byte_accept (byte_accept),
      .data_byte   (req_payload.data_byte),
      .job         (job)
   );

   assign a_error = (a_job_ff.kind == KIND_ERROR);
   assign use_ram = (a_job_ff.kind == KIND_PAL1) || (a_job_ff.kind == KIND_PAL4) ||
                    (a_job_ff.kind == KIND_PAL8);

   // Palette index of the current pixel: bits most significant first at one bit
   // per pixel, high nibble first at four.
   always_comb begin
      unique case (a_job_ff.kind)
         KIND_PAL1: rd_addr = PAL_AW'(a_job_ff.data_byte[SLOT_W'(MAX_RESULTS - 1) - a_k_ff]);
         KIND_PAL4: rd_addr = (a_k_ff == '0) ? PAL_AW'(a_job_ff.data_byte[7:4])
                                             : PAL_AW'(a_job_ff.data_byte[3:0]);
         default:   rd_addr = PAL_AW'(a_job_ff.data_byte);
      endcase
   end

   bpu_ram #(
      .WIDTH (RGB_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock (clock),
      .we    (pal_we),
      .waddr (req_payload.palette_index),
      .wdata ({req_payload.palette_red, req_payload.palette_green, req_payload.palette_blue}),
      .re    (issue && use_ram),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   always_comb begin
      a_valid_in = a_valid_ff;
      a_job_in   = a_job_ff;
      a_cnt_in   = a_cnt_ff;
      a_k_in     = a_k_ff;
      a_col_in   = a_col_ff;
      if (issue) begin
         a_cnt_in = a_cnt_ff - RUN_W'(1);
         a_k_in   = a_k_ff + SLOT_W'(1);
         a_col_in = a_col_ff + CNT_W'(1);
         if (a_last) begin
            a_valid_in = 1'b0;
         end
      end
      if (byte_accept && job.valid) begin
         a_valid_in = 1'b1;
         a_job_in   = job;
         a_cnt_in   = job.count;
         a_k_in     = '0;
         a_col_in   = job.first_col;
      end
   end

   // Error results carry zero position, color and frame_done.
   always_comb begin
      b_valid_in   = b_valid_ff;
      b_use_ram_in = b_use_ram_ff;
      b_rgb_in     = b_rgb_ff;
      b_col_in     = b_col_ff;
      b_row_in     = b_row_ff;
      b_status_in  = b_status_ff;
      b_last_in    = b_last_ff;
      b_done_in    = b_done_ff;
      if (issue) begin
         b_valid_in   = 1'b1;
         b_use_ram_in = use_ram;
         b_rgb_in     = (a_job_ff.kind == KIND_RGB) ? a_job_ff.rgb : '0;
         b_col_in     = a_error ? '0 : a_col_ff[COL_W-1:0];
         b_row_in     = a_error ? '0 : a_job_ff.row_out;
         b_status_in  = a_job_ff.status;
         b_last_in    = a_last;
         b_done_in    = !a_error && a_job_ff.last_row && (a_col_ff == a_job_ff.last_col);
      end else if (b_move) begin
         b_valid_in = 1'b0;
      end
   end

   assign color = b_use_ram_ff ? ram_rdata : b_rgb_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (b_move) begin
         rsp_valid_in        = 1'b1;
         rsp_in.pixel_column = b_col_ff;
         rsp_in.pixel_row    = b_row_ff;
         rsp_in.out_red      = color[23:16];
         rsp_in.out_green    = color[15:8];
         rsp_in.out_blue     = color[7:0];
         rsp_in.status       = b_status_ff;
         rsp_in.last_of_run  = b_last_ff;
         rsp_in.frame_done   = b_done_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_job_ff     <= a_job_in;
      a_cnt_ff     <= a_cnt_in;
      a_k_ff       <= a_k_in;
      a_col_ff     <= a_col_in;
      b_use_ram_ff <= b_use_ram_in;
      b_rgb_ff     <= b_rgb_in;
      b_col_ff     <= b_col_in;
      b_row_ff     <= b_row_in;
      b_status_ff  <= b_status_in;
      b_last_ff    <= b_last_in;
      b_done_ff    <= b_done_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `BPU_ASSERT_SAME(a_count_range, clock, reset, a_valid_ff, (a_cnt_ff != '0) && (a_cnt_ff <= RUN_W'(MAX_RESULTS)), "job holds no pending or too many results")
   `BPU_ASSERT_NEXT(b_follows_issue, clock, reset, issue, b_valid_ff, "issued lookup did not reach the read data stage")
   `BPU_ASSERT_SAME(error_is_single, clock, reset, rsp_valid_ff && (rsp_ff.status != STATUS_PIXEL), rsp_ff.last_of_run && !rsp_ff.frame_done, "error result is not a lone final result")
   `BPU_ASSERT_SAME(done_ends_run, clock, reset, rsp_valid_ff && rsp_ff.frame_done, rsp_ff.last_of_run, "final pixel of the frame is not the last result of its byte")

endmodule
